/* rtl/pts_pkg.sv */
// Shared types and constants for the prime test / prime sum block.
// Beat payloads plus the command and status bundles between controller
// and datapath. No dependencies.
package pts_pkg;

   // Fixed field widths of the channel payloads
   localparam int N_W       = 32;
   localparam int SUM_OUT_W = 63;

   // Operation codes
   localparam logic OP_TEST = 1'b0;
   localparam logic OP_SUM  = 1'b1;

   typedef struct packed {
      logic                  op;
      logic signed [N_W-1:0] n;
   } req_type;

   typedef struct packed {
      logic                 is_prime;
      logic [SUM_OUT_W-1:0] prime_sum;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;    // latch request beat and set up the candidate range
      logic mark_prime; // current candidate has no divisor
      logic mark_comp;  // current candidate has a divisor
      logic start_div;  // start remainder of candidate by trial divisor
      logic step_div;   // advance trial divisor and its square
      logic step_cand;  // advance to next candidate, reset trial divisor
      logic finish;     // load the result register
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic empty;      // candidate range is empty
      logic sq_gt;      // divisor squared exceeds candidate
      logic last;       // candidate is the last in range
      logic div_done;   // remainder ready
      logic div_zero;   // remainder is zero
      logic out_free;   // result register can take a new beat
   } sts_type;

endpackage

/* rtl/pts_rem.sv */
// Iterative restoring remainder unit: one dividend bit per cycle.
// Produces only the zero test of the remainder. Depends on nothing.
module pts_rem #(
   parameter int W = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic         zero
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W:0]    trial;
   logic [W-1:0]  diff;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      // when the divisor fits, the true difference is below the divisor
      diff    = trial[W-1:0] - divisor;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? diff : trial[W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign zero = (rem_ff == '0);

endmodule

/* rtl/pts_dpath.sv */
// Datapath: candidate, trial divisor and square, running sum, result register.
// Uses pts_pkg types and the pts_rem remainder unit.
module pts_dpath #(
   parameter int N_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  pts_pkg::req_type req_data,
   input  pts_pkg::cmd_type cmd,
   output pts_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pts_pkg::rsp_type rsp_data
);

   localparam int UW    = N_BITS - 1;
   localparam int SUM_W = 2 * UW;
   localparam int PAD_W = pts_pkg::SUM_OUT_W - SUM_W;

   localparam logic signed [N_BITS-1:0] ONE = N_BITS'(1);
   localparam logic signed [N_BITS-1:0] TWO = N_BITS'(2);

   logic               op_ff;
   logic               empty_ff;
   logic [UW-1:0]      cand_ff;
   logic [UW-1:0]      limit_ff;
   logic [UW-1:0]      d_ff;
   logic [N_BITS-1:0]  sq_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               flag_ff;
   logic               rsp_valid_ff;
   pts_pkg::rsp_type   rsp_ff;

   logic signed [N_BITS-1:0] n_v;
   logic [UW-1:0]            n_m1;
   logic                     div_done;
   logic                     div_zero;

   assign n_v  = req_data.n[N_BITS-1:0];
   assign n_m1 = UW'(n_v - ONE);

   pts_rem #(.W(UW)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (cand_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .zero     (div_zero)
   );

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_data.op;
         sum_ff  <= '0;
         flag_ff <= 1'b0;
         d_ff    <= UW'(2);
         sq_ff   <= N_BITS'(4);
         if (req_data.op == pts_pkg::OP_SUM) begin
            // sum mode: candidates 2 .. n-1
            empty_ff <= (n_v <= TWO);
            cand_ff  <= UW'(2);
            limit_ff <= n_m1;
         end else begin
            // test mode: the single candidate n
            empty_ff <= (n_v <= ONE);
            cand_ff  <= n_v[UW-1:0];
            limit_ff <= n_v[UW-1:0];
         end
      end else begin
         if (cmd.mark_prime) begin
            flag_ff <= 1'b1;
            if (op_ff == pts_pkg::OP_SUM) begin
               sum_ff <= sum_ff + SUM_W'(cand_ff);
            end
         end
         if (cmd.mark_comp) begin
            flag_ff <= 1'b0;
         end
         // (d+1)^2 = d^2 + 2d + 1
         if (cmd.step_div) begin
            d_ff  <= d_ff + UW'(1);
            sq_ff <= sq_ff + {d_ff, 1'b1};
         end
         if (cmd.step_cand) begin
            cand_ff <= cand_ff + UW'(1);
            d_ff    <= UW'(2);
            sq_ff   <= N_BITS'(4);
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff.is_prime  <= flag_ff & (op_ff == pts_pkg::OP_TEST);
         rsp_ff.prime_sum <= {{PAD_W{1'b0}}, sum_ff};
      end
   end

   assign sts.empty    = empty_ff;
   assign sts.sq_gt    = (sq_ff > {1'b0, cand_ff});
   assign sts.last     = (cand_ff == limit_ff);
   assign sts.div_done = div_done;
   assign sts.div_zero = div_zero;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/pts_ctrl.sv */
// Controller: sequences candidates and trial divisors for one request beat.
// Uses pts_pkg command and status bundles.
module pts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pts_pkg::sts_type sts,
   output pts_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_DIV,
      ST_NEXT,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            state_in = sts.empty ? ST_FIN : ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.sq_gt) begin
               cmd.mark_prime = 1'b1;
               state_in       = ST_NEXT;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               if (sts.div_zero) begin
                  cmd.mark_comp = 1'b1;
                  state_in      = ST_NEXT;
               end else begin
                  cmd.step_div = 1'b1;
                  state_in     = ST_CHECK;
               end
            end
         end
         ST_NEXT: begin
            if (sts.last) begin
               state_in = ST_FIN;
            end else begin
               cmd.step_cand = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/prime_test_and_prime_sum.sv */
// Prime test and prime sum by trial division.
// Channels: req (op, signed n) in, rsp (is_prime, prime_sum) out, both
// valid/stall; a beat moves when valid is high and stall is low.
// op 0 tests n for primality; op 1 sums all primes below n. Only the low
// N_BITS bits of n are used, bit N_BITS-1 being the sign.
// One request beat gives exactly one response beat. Requests are worked
// one at a time: req_stall is high from the accept until the result is
// loaded into the response register.
// Each trial division is started, stepped through the N_BITS-1 dividend
// bits by the bit-serial remainder unit, and its result is then read. A
// prime test of n needs up to floor(sqrt(n))-1 such divisions. A prime
// sum runs the same test on every candidate from 2 to n-1, so its run
// time is the sum of those test times.
// A response held by rsp_stall stays in the output register; the next
// request is still accepted and worked, and its result waits until the
// register frees. Reset (synchronous) returns to idle with no beat pending.
// Depends on pts_pkg, pts_ctrl, pts_dpath, pts_rem.
module prime_test_and_prime_sum #(
   parameter int N_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pts_pkg::rsp_type rsp_data
);

   pts_pkg::cmd_type cmd;
   pts_pkg::sts_type sts;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pts_dpath #(.N_BITS(N_BITS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
